[sv/tog_pkg.sv]
// ----------------------------------------------------------------------------
// tog_pkg: shared types and constants for the tile order generator
// Holds the control word format, the microprogram and field widths.
// ----------------------------------------------------------------------------
package tog_pkg;

  localparam int unsigned COORD_W   = 4;   // tile column / row index
  localparam int unsigned DCOUNT_W  = 4;   // division_count field
  localparam int unsigned PIX_W     = 14;  // pixel coordinate and image size
  localparam int unsigned PROD_W    = PIX_W + COORD_W;
  localparam int unsigned DIV_STEPS = PIX_W;
  localparam int unsigned PC_W      = 4;

  localparam logic [PIX_W-1:0] IMG_MAX = PIX_W'(8192);

  // order_mode codes
  localparam logic MODE_GRID   = 1'b0;
  localparam logic MODE_SPIRAL = 1'b1;

  // configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // microprogram step addresses
  localparam logic [PC_W-1:0] ST_IDLE    = 4'd0;
  localparam logic [PC_W-1:0] ST_DIVWAIT = 4'd1;
  localparam logic [PC_W-1:0] ST_MODESEL = 4'd2;
  localparam logic [PC_W-1:0] ST_GRID    = 4'd3;
  localparam logic [PC_W-1:0] ST_RET     = 4'd4;
  localparam logic [PC_W-1:0] ST_SPRO    = 4'd5;
  localparam logic [PC_W-1:0] ST_SPCOL   = 4'd6;
  localparam logic [PC_W-1:0] ST_SPSETUP = 4'd7;
  localparam logic [PC_W-1:0] ST_XLEG    = 4'd8;
  localparam logic [PC_W-1:0] ST_YLEG    = 4'd9;
  localparam logic [PC_W-1:0] ST_TURN    = 4'd10;
  localparam logic [PC_W-1:0] ST_CENTER  = 4'd11;

  typedef enum logic [2:0] {
    CO_HOLD        = 3'd0,
    CO_ZERO        = 3'd1,
    CO_LOAD_TOP    = 3'd2,  // d - 1
    CO_DEC         = 3'd3,
    CO_ADV         = 3'd4,  // step along walk direction
    CO_WRAP_DEC    = 3'd5,  // column: d-1 after zero, else decrement
    CO_DEC_ON_WRAP = 3'd6   // row: decrement when column is zero
  } coord_op_e;

  typedef enum logic [1:0] {
    PO_HOLD = 2'd0,
    PO_ZERO = 2'd1,
    PO_STEP = 2'd2   // increment, back to zero at end of leg
  } pos_op_e;

  typedef enum logic [1:0] {
    LO_HOLD = 2'd0,
    LO_LOAD = 2'd1,
    LO_DEC  = 2'd2
  } leg_op_e;

  typedef enum logic [1:0] {
    DO_HOLD = 2'd0,
    DO_CLR  = 2'd1,
    DO_FLIP = 2'd2
  } dir_op_e;

  typedef enum logic [3:0] {
    C_ALWAYS      = 4'd0,
    C_NO_INPUT    = 4'd1,
    C_DIV_BUSY    = 4'd2,
    C_SPIRAL      = 4'd3,
    C_ROW_ZERO    = 4'd4,
    C_ROW_NOT_ONE = 4'd5,
    C_D_ONE       = 4'd6,
    C_POS_MORE    = 4'd7,
    C_LEG_NOT_ONE = 4'd8,
    C_NOT_LAST    = 4'd9
  } cond_e;

  typedef struct packed {
    logic              accept;
    logic              emit;
    coord_op_e         col_op;
    coord_op_e         row_op;
    pos_op_e           pos_op;
    leg_op_e           leg_op;
    dir_op_e           dir_op;
    cond_e             cond;
    logic [PC_W-1:0]   target;
  } ucode_t;

  // sequencer -> datapath
  typedef struct packed {
    logic      go;      // step completes this cycle
    logic      load;    // request accepted
    logic      emit;
    coord_op_e col_op;
    coord_op_e row_op;
    pos_op_e   pos_op;
    leg_op_e   leg_op;
    dir_op_e   dir_op;
  } ctrl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic div_busy;
    logic spiral;
    logic row_zero;
    logic row_one;
    logic d_one;
    logic pos_last;
    logic leg_one;
    logic last_tile;
    logic out_free;
  } status_t;

  function automatic ucode_t uc(logic acc, logic emt, coord_op_e co, coord_op_e ro,
                                pos_op_e po, leg_op_e lo, dir_op_e dop,
                                cond_e cnd, logic [PC_W-1:0] tgt);
    ucode_t w;
    w.accept = acc;
    w.emit   = emt;
    w.col_op = co;
    w.row_op = ro;
    w.pos_op = po;
    w.leg_op = lo;
    w.dir_op = dop;
    w.cond   = cnd;
    w.target = tgt;
    return w;
  endfunction

  // Microprogram: next step is target when the condition holds, else pc + 1.
  function automatic ucode_t ucode_fetch(logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      ST_IDLE:    w = uc(1'b1, 1'b0, CO_HOLD, CO_HOLD, PO_HOLD, LO_HOLD, DO_HOLD,
                         C_NO_INPUT, ST_IDLE);
      ST_DIVWAIT: w = uc(1'b0, 1'b0, CO_HOLD, CO_HOLD, PO_HOLD, LO_HOLD, DO_HOLD,
                         C_DIV_BUSY, ST_DIVWAIT);
      ST_MODESEL: w = uc(1'b0, 1'b0, CO_LOAD_TOP, CO_LOAD_TOP, PO_HOLD, LO_HOLD,
                         DO_HOLD, C_SPIRAL, ST_SPRO);
      ST_GRID:    w = uc(1'b0, 1'b1, CO_WRAP_DEC, CO_DEC_ON_WRAP, PO_HOLD, LO_HOLD,
                         DO_HOLD, C_NOT_LAST, ST_GRID);
      ST_RET:     w = uc(1'b0, 1'b0, CO_HOLD, CO_HOLD, PO_HOLD, LO_HOLD, DO_HOLD,
                         C_ALWAYS, ST_IDLE);
      ST_SPRO:    w = uc(1'b0, 1'b0, CO_ZERO, CO_HOLD, PO_HOLD, LO_HOLD, DO_HOLD,
                         C_ROW_ZERO, ST_SPSETUP);
      ST_SPCOL:   w = uc(1'b0, 1'b1, CO_HOLD, CO_DEC, PO_HOLD, LO_HOLD, DO_HOLD,
                         C_ROW_NOT_ONE, ST_SPCOL);
      ST_SPSETUP: w = uc(1'b0, 1'b0, CO_ZERO, CO_ZERO, PO_ZERO, LO_LOAD, DO_CLR,
                         C_D_ONE, ST_CENTER);
      ST_XLEG:    w = uc(1'b0, 1'b1, CO_ADV, CO_HOLD, PO_STEP, LO_HOLD, DO_HOLD,
                         C_POS_MORE, ST_XLEG);
      ST_YLEG:    w = uc(1'b0, 1'b1, CO_HOLD, CO_ADV, PO_STEP, LO_HOLD, DO_HOLD,
                         C_POS_MORE, ST_YLEG);
      ST_TURN:    w = uc(1'b0, 1'b0, CO_HOLD, CO_HOLD, PO_HOLD, LO_DEC, DO_FLIP,
                         C_LEG_NOT_ONE, ST_XLEG);
      ST_CENTER:  w = uc(1'b0, 1'b1, CO_HOLD, CO_HOLD, PO_HOLD, LO_HOLD, DO_HOLD,
                         C_ALWAYS, ST_IDLE);
      default:    w = uc(1'b0, 1'b0, CO_HOLD, CO_HOLD, PO_HOLD, LO_HOLD, DO_HOLD,
                         C_ALWAYS, ST_IDLE);
    endcase
    return w;
  endfunction

endpackage

[sv/tog_ceil_div.sv]
// ----------------------------------------------------------------------------
// tog_ceil_div: iterative restoring divider
// One quotient bit per cycle; divides a pixel count by a small tile count.
// ----------------------------------------------------------------------------
module tog_ceil_div import tog_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [PIX_W-1:0]    dividend_i,
  input  logic [DCOUNT_W-1:0] divisor_i,
  output logic                busy_o,
  output logic [PIX_W-1:0]    quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIV_STEPS + 1);

  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [PIX_W-1:0]    dvd_q, dvd_d;
  logic [DCOUNT_W-1:0] rem_q, rem_d;
  logic [DCOUNT_W-1:0] dsr_q, dsr_d;
  logic [DCOUNT_W:0]   rem_sh;
  logic                ge;

  assign rem_sh = {rem_q, dvd_q[PIX_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    cnt_d = cnt_q;
    dvd_d = dvd_q;
    rem_d = rem_q;
    dsr_d = dsr_q;
    if (start_i) begin
      cnt_d = CNT_W'(DIV_STEPS);
      dvd_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
    end else if (busy_o) begin
      cnt_d = cnt_q - 1'b1;
      dvd_d = {dvd_q[PIX_W-2:0], ge};
      rem_d = ge ? DCOUNT_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[DCOUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = dvd_q;

endmodule

[sv/tog_useq.sv]
// ----------------------------------------------------------------------------
// tog_useq: microcode sequencer
// Step counter over the control store with conditional jumps.
// ----------------------------------------------------------------------------
module tog_useq import tog_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  status_t status_i,
  output logic    in_ready_o,
  output ctrl_t   ctrl_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  ucode_t          word;
  logic            take;
  logic            go;

  assign word = ucode_fetch(pc_q);

  always_comb begin
    case (word.cond)
      C_ALWAYS:      take = 1'b1;
      C_NO_INPUT:    take = !in_valid_i;
      C_DIV_BUSY:    take = status_i.div_busy;
      C_SPIRAL:      take = status_i.spiral;
      C_ROW_ZERO:    take = status_i.row_zero;
      C_ROW_NOT_ONE: take = !status_i.row_one;
      C_D_ONE:       take = status_i.d_one;
      C_POS_MORE:    take = !status_i.pos_last;
      C_LEG_NOT_ONE: take = !status_i.leg_one;
      C_NOT_LAST:    take = !status_i.last_tile;
      default:       take = 1'b1;
    endcase
  end

  // hold the step while a tile waits for the output register
  assign go = !(word.emit && !status_i.out_free);

  always_comb begin
    pc_d = pc_q;
    if (go) begin
      pc_d = take ? word.target : pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign in_ready_o    = word.accept;
  assign ctrl_o.go     = go;
  assign ctrl_o.load   = word.accept && in_valid_i;
  assign ctrl_o.emit   = word.emit;
  assign ctrl_o.col_op = word.col_op;
  assign ctrl_o.row_op = word.row_op;
  assign ctrl_o.pos_op = word.pos_op;
  assign ctrl_o.leg_op = word.leg_op;
  assign ctrl_o.dir_op = word.dir_op;

endmodule

[sv/tog_dpath.sv]
// ----------------------------------------------------------------------------
// tog_dpath: walker registers, tile arithmetic and output register
// Applies the control word ops and forms one tile rectangle per emit.
// ----------------------------------------------------------------------------
module tog_dpath import tog_pkg::*; #(
  parameter int unsigned MAX_DIVISIONS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_t               ctrl_i,
  output status_t             status_o,
  input  logic [DCOUNT_W-1:0] div_count_i,
  input  logic                mode_i,
  input  logic [PIX_W-1:0]    img_w_i,
  input  logic [PIX_W-1:0]    img_h_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PIX_W-1:0]    x_start_o,
  output logic [PIX_W-1:0]    x_end_o,
  output logic [PIX_W-1:0]    y_start_o,
  output logic [PIX_W-1:0]    y_end_o,
  output logic                last_o
);

  localparam int unsigned CNT_W = $clog2(MAX_DIVISIONS * MAX_DIVISIONS + 1);
  localparam logic [DCOUNT_W-1:0] D_MAX = DCOUNT_W'(MAX_DIVISIONS);

  logic [DCOUNT_W-1:0] d_sat;
  logic [DCOUNT_W-1:0] d_q;
  logic                mode_q;
  logic [CNT_W-1:0]    total_m1_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [COORD_W-1:0]  col_q, col_d, row_q, row_d;
  logic [COORD_W-1:0]  pos_q, pos_d, leg_q, leg_d;
  logic                dir_q, dir_d;
  logic [COORD_W-1:0]  top_idx;
  logic                busy_x, busy_y;
  logic [PIX_W-1:0]    step_x, step_y;
  logic                emit_go;
  logic                out_valid_q;
  logic [PROD_W-1:0]   xs, xe, ys, ye;
  logic [PIX_W-1:0]    xe_c, ye_c;

  always_comb begin
    if (div_count_i == '0) begin
      d_sat = DCOUNT_W'(1);
    end else if (div_count_i > D_MAX) begin
      d_sat = D_MAX;
    end else begin
      d_sat = div_count_i;
    end
  end

  // ceil(size / d) as (size + d - 1) / d on both axes at once
  tog_ceil_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.load),
    .dividend_i (img_w_i + PIX_W'(d_sat) - PIX_W'(1)),
    .divisor_i  (d_sat),
    .busy_o     (busy_x),
    .quotient_o (step_x)
  );

  tog_ceil_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.load),
    .dividend_i (img_h_i + PIX_W'(d_sat) - PIX_W'(1)),
    .divisor_i  (d_sat),
    .busy_o     (busy_y),
    .quotient_o (step_y)
  );

  assign top_idx = d_q - 1'b1;
  assign emit_go = ctrl_i.go && ctrl_i.emit;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    pos_d = pos_q;
    leg_d = leg_q;
    dir_d = dir_q;
    if (ctrl_i.go) begin
      case (ctrl_i.col_op)
        CO_ZERO:     col_d = '0;
        CO_LOAD_TOP: col_d = top_idx;
        CO_DEC:      col_d = col_q - 1'b1;
        CO_ADV:      col_d = dir_q ? col_q - 1'b1 : col_q + 1'b1;
        CO_WRAP_DEC: col_d = (col_q == '0) ? top_idx : col_q - 1'b1;
        default:     col_d = col_q;
      endcase
      case (ctrl_i.row_op)
        CO_ZERO:        row_d = '0;
        CO_LOAD_TOP:    row_d = top_idx;
        CO_DEC:         row_d = row_q - 1'b1;
        CO_ADV:         row_d = dir_q ? row_q - 1'b1 : row_q + 1'b1;
        CO_DEC_ON_WRAP: row_d = (col_q == '0) ? row_q - 1'b1 : row_q;
        default:        row_d = row_q;
      endcase
      case (ctrl_i.pos_op)
        PO_ZERO: pos_d = '0;
        PO_STEP: pos_d = status_o.pos_last ? '0 : pos_q + 1'b1;
        default: pos_d = pos_q;
      endcase
      case (ctrl_i.leg_op)
        LO_LOAD: leg_d = top_idx;
        LO_DEC:  leg_d = leg_q - 1'b1;
        default: leg_d = leg_q;
      endcase
      case (ctrl_i.dir_op)
        DO_CLR:  dir_d = 1'b0;
        DO_FLIP: dir_d = !dir_q;
        default: dir_d = dir_q;
      endcase
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      cnt_d = '0;
    end else if (emit_go) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // tile rectangle; grid order clamps the end to the image
  assign xs = PROD_W'(col_q) * PROD_W'(step_x);
  assign ys = PROD_W'(row_q) * PROD_W'(step_y);
  assign xe = xs + PROD_W'(step_x);
  assign ye = ys + PROD_W'(step_y);
  assign xe_c = (mode_q == MODE_GRID && xe > PROD_W'(img_w_i)) ? img_w_i : xe[PIX_W-1:0];
  assign ye_c = (mode_q == MODE_GRID && ye > PROD_W'(img_h_i)) ? img_h_i : ye[PIX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      pos_q       <= '0;
      leg_q       <= '0;
      dir_q       <= 1'b0;
      cnt_q       <= '0;
      d_q         <= DCOUNT_W'(1);
      mode_q      <= MODE_GRID;
      total_m1_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      pos_q <= pos_d;
      leg_q <= leg_d;
      dir_q <= dir_d;
      cnt_q <= cnt_d;
      if (ctrl_i.load) begin
        d_q        <= d_sat;
        mode_q     <= mode_i;
        total_m1_q <= CNT_W'(CNT_W'(d_sat) * CNT_W'(d_sat) - 1'b1);
      end
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      x_start_o <= xs[PIX_W-1:0];
      x_end_o   <= xe_c;
      y_start_o <= ys[PIX_W-1:0];
      y_end_o   <= ye_c;
      last_o    <= status_o.last_tile;
    end
  end

  assign out_valid_o = out_valid_q;

  assign status_o.div_busy  = busy_x || busy_y;
  assign status_o.spiral    = (mode_q == MODE_SPIRAL);
  assign status_o.row_zero  = (row_q == '0);
  assign status_o.row_one   = (row_q == COORD_W'(1));
  assign status_o.d_one     = (d_q == DCOUNT_W'(1));
  assign status_o.pos_last  = (COORD_W'(pos_q + 1'b1) == leg_q);
  assign status_o.leg_one   = (leg_q == COORD_W'(1));
  assign status_o.last_tile = (cnt_q == total_m1_q);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

[sv/tile_order_generator_unit.sv]
// ----------------------------------------------------------------------------
// Start-up: a request passes the accept step, the step dividers and the setup
// steps before its first tile enters the output register.
// Throughput: d*d tiles at one tile per cycle while the output register is free; a
// spiral adds one turn step per leg pair. A new request is taken only after the last tile.
// Reset: sequencer returns to idle, output empties, image size goes to 640 x 480.
// ----------------------------------------------------------------------------
// tile_order_generator_unit: tile queue for an image split into d x d tiles
// Takes one request (division count, order mode) and streams every tile
// rectangle in grid or inward-spiral order, with tlast on the final tile.
// ----------------------------------------------------------------------------
module tile_order_generator_unit import tog_pkg::*; #(
  parameter int unsigned MAX_DIVISIONS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // request stream
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [7:0]       s_axis_tdata_i,   // [3:0] division_count, [4] order_mode
  // tile stream
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [55:0]      m_axis_tdata_o,   // [13:0] x_start, [27:14] x_end,
                                             // [41:28] y_start, [55:42] y_end
  output logic             m_axis_tlast_o,   // last_tile
  // configuration writes
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [PIX_W-1:0] cfg_data_i
);

  logic [PIX_W-1:0] img_w_q, img_h_q;
  logic [PIX_W-1:0] img_w, img_h;
  ctrl_t            ctrl_s;
  status_t          status_s;
  logic [PIX_W-1:0] x_start, x_end, y_start, y_end;

  // Image size registers; the user must write them only while no request is in flight; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= PIX_W'(640);
      img_h_q <= PIX_W'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH:  img_w_q <= cfg_data_i;
        REG_IMAGE_HEIGHT: img_h_q <= cfg_data_i;
        default:          img_w_q <= img_w_q;
      endcase
    end
  end

  // Force an empty image to one pixel and cap it at the largest size.
  assign img_w = (img_w_q == '0) ? PIX_W'(1) : ((img_w_q > IMG_MAX) ? IMG_MAX : img_w_q);
  assign img_h = (img_h_q == '0) ? PIX_W'(1) : ((img_h_q > IMG_MAX) ? IMG_MAX : img_h_q);

  // Sequencer: walks the control store, one control word per step.
  tog_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .status_i   (status_s),
    .in_ready_o (s_axis_tready_o),
    .ctrl_o     (ctrl_s)
  );

  // Datapath: walker coordinates, step dividers, tile math, output register.
  tog_dpath #(
    .MAX_DIVISIONS (MAX_DIVISIONS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl_s),
    .status_o    (status_s),
    .div_count_i (s_axis_tdata_i[DCOUNT_W-1:0]),
    .mode_i      (s_axis_tdata_i[DCOUNT_W]),
    .img_w_i     (img_w),
    .img_h_i     (img_h),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .x_start_o   (x_start),
    .x_end_o     (x_end),
    .y_start_o   (y_start),
    .y_end_o     (y_end),
    .last_o      (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {y_end, y_start, x_end, x_start};

  // A request moves the sequencer out of its accept step right away.
  a_accept_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("request accept did not leave the idle step");

  // The step dividers are never running while a new request may be taken.
  a_no_accept_while_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !status_s.div_busy)
    else $error("ready for a request while the dividers are busy");

  // A fresh tile only comes out of a request that is being worked on.
  a_tile_in_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("tile emitted outside a request");

endmodule
